/* rtl/core/swfr_pkg.sv */
// Shared types and constants of the serial word frame receiver.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package swfr_pkg;

	// frame verdict carried with each word
	typedef enum logic [2:0] {
		STATUS_IN_FRAME  = 3'd0,
		STATUS_OK        = 3'd1,
		STATUS_ADDR_BAD  = 3'd2,
		STATUS_SUM_BAD   = 3'd3,
		STATUS_LEN_BAD   = 3'd4
	} status_t;

	// input command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// header bytes that open a frame
	localparam logic [7:0] HDR_A = 8'h99;
	localparam logic [7:0] HDR_B = 8'h13;
	localparam logic [7:0] HDR_C = 8'h14;

	// smallest accepted value of the length word
	localparam logic [15:0] MIN_LEN = 16'd3;

	// configuration register indexes
	localparam logic REG_BOARD_ID = 1'b0;
	localparam logic REG_TIMEOUT  = 1'b1;

	// one result item
	typedef struct packed {
		logic [15:0] word_value;
		logic [6:0]  word_index;
		logic        frame_end;
		status_t     status;
	} out_item_t;

	// configuration seen by the frame logic
	typedef struct packed {
		logic [15:0] board_id;
		logic [15:0] timeout_ticks;
	} cfg_t;

	function automatic logic is_header(input logic [7:0] b);
		is_header = (b == HDR_A) || (b == HDR_B) || (b == HDR_C);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/swfr_cfg.sv */
// APB-style configuration registers: board id and timeout.
// Depends on swfr_pkg.
`default_nettype none

module swfr_cfg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output swfr_pkg::cfg_t      cfg
);

	logic        wr_en;
	logic        reg_sel;
	logic [15:0] board_id_q;
	logic [15:0] timeout_q;

	assign wr_en   = psel & penable & pwrite;
	// registers sit on 4-byte steps; low address bits ignored
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_id_q <= 16'd0;
			timeout_q  <= 16'd1;
		end else if (wr_en) begin
			unique case (reg_sel)
				swfr_pkg::REG_BOARD_ID: board_id_q <= pwdata[15:0];
				swfr_pkg::REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			swfr_pkg::REG_BOARD_ID: prdata = {16'd0, board_id_q};
			swfr_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign cfg.board_id      = board_id_q;
	assign cfg.timeout_ticks = timeout_q;

endmodule

`default_nettype wire

/* rtl/core/swfr_frame.sv */
// Frame state: header hunt, word pairing, length check, sum and verdict, timeout.
// Depends on swfr_pkg.
`default_nettype none

module swfr_frame #(
	parameter int MAX_WORDS = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    take,
	input  wire                    cmd,
	input  wire  [7:0]             byte_value,
	input  swfr_pkg::cfg_t         cfg,
	output logic                   res_valid,
	output swfr_pkg::out_item_t    res
);

	localparam logic [16:0] MaxWordsW = 17'(MAX_WORDS);

	logic        hunting_q, timed_out_q, addr_match_q, timer_run_q;
	logic [8:0]  byte_cnt_q;
	logic [7:0]  high_byte_q, frame_words_q;
	logic [15:0] sum_q, idle_q;

	logic        hunting_d, timed_out_d, addr_match_d, timer_run_d;
	logic [8:0]  byte_cnt_d;
	logic [7:0]  high_byte_d, frame_words_d;
	logic [15:0] sum_d, idle_d;

	logic        hunt_now, open_frame;
	logic [8:0]  cnt_base;
	logic [7:0]  fw_base, idx;
	logic [15:0] sum_base, word, idle_inc;
	logic        am_base;

	assign word     = {high_byte_q, byte_value};
	assign hunt_now = hunting_q | timed_out_q;
	assign open_frame = hunt_now & swfr_pkg::is_header(byte_value);
	assign cnt_base = open_frame ? 9'd0 : byte_cnt_q;
	assign fw_base  = open_frame ? 8'd0 : frame_words_q;
	assign sum_base = open_frame ? 16'd0 : sum_q;
	assign am_base  = open_frame ? 1'b0 : addr_match_q;
	assign idx      = cnt_base[8:1];
	assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

	always_comb begin
		hunting_d     = hunting_q;
		timed_out_d   = timed_out_q;
		addr_match_d  = addr_match_q;
		timer_run_d   = timer_run_q;
		byte_cnt_d    = byte_cnt_q;
		high_byte_d   = high_byte_q;
		frame_words_d = frame_words_q;
		sum_d         = sum_q;
		idle_d        = idle_q;
		res_valid     = 1'b0;
		res.word_value = word;
		res.word_index = idx[6:0];
		res.frame_end  = 1'b0;
		res.status     = swfr_pkg::STATUS_IN_FRAME;

		if (cmd == swfr_pkg::CMD_TICK) begin
			if (timer_run_q) begin
				idle_d = idle_inc;
				// a zero limit behaves as one, since the count is at least one here
				if (idle_inc >= cfg.timeout_ticks) begin
					timer_run_d = 1'b0;
					timed_out_d = 1'b1;
				end
			end
		end else begin
			idle_d      = 16'd0;
			timer_run_d = 1'b1;
			timed_out_d = 1'b0;
			hunting_d   = hunt_now;
			if (!hunt_now || open_frame) begin
				hunting_d     = 1'b0;
				byte_cnt_d    = cnt_base + 9'd1;
				frame_words_d = fw_base;
				sum_d         = sum_base;
				addr_match_d  = am_base;
				if (!cnt_base[0]) begin
					high_byte_d = byte_value;
				end else begin
					res_valid = 1'b1;
					priority if (idx == 8'd1 &&
							({1'b0, word} >= MaxWordsW || word < swfr_pkg::MIN_LEN)) begin
						hunting_d     = 1'b1;
						res.frame_end = 1'b1;
						res.status    = swfr_pkg::STATUS_LEN_BAD;
					end else if (idx == 8'd1) begin
						// the length word is never the last word
						frame_words_d = word[7:0];
						sum_d         = sum_base + word;
					end else if (fw_base != 8'd0 && idx == fw_base) begin
						hunting_d     = 1'b1;
						timer_run_d   = 1'b0;
						res.frame_end = 1'b1;
						if (!am_base)
							res.status = swfr_pkg::STATUS_ADDR_BAD;
						else if (sum_base != word)
							res.status = swfr_pkg::STATUS_SUM_BAD;
						else
							res.status = swfr_pkg::STATUS_OK;
					end else begin
						if (idx == 8'd2)
							addr_match_d = (word == cfg.board_id);
						sum_d = sum_base + word;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q     <= 1'b1;
			timed_out_q   <= 1'b0;
			addr_match_q  <= 1'b0;
			timer_run_q   <= 1'b0;
			byte_cnt_q    <= 9'd0;
			high_byte_q   <= 8'd0;
			frame_words_q <= 8'd0;
			sum_q         <= 16'd0;
			idle_q        <= 16'd0;
		end else if (take) begin
			hunting_q     <= hunting_d;
			timed_out_q   <= timed_out_d;
			addr_match_q  <= addr_match_d;
			timer_run_q   <= timer_run_d;
			byte_cnt_q    <= byte_cnt_d;
			high_byte_q   <= high_byte_d;
			frame_words_q <= frame_words_d;
			sum_q         <= sum_d;
			idle_q        <= idle_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/swfr_out_buf.sv */
// Output register with a skid stage, so the input side keeps moving while one result waits.
// Depends on swfr_pkg.
`default_nettype none

module swfr_out_buf (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  swfr_pkg::out_item_t    push_item,
	output logic                   can_push,
	output logic                   out_valid,
	input  wire                    out_ready,
	output swfr_pkg::out_item_t    out_item
);

	logic                 out_valid_q, skid_valid_q;
	swfr_pkg::out_item_t  out_q, skid_q;
	logic                 pop;

	assign pop       = out_valid_q & out_ready;
	assign can_push  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_q <= push_item;
			else
				skid_q <= push_item;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/serial_word_frame_receiver_unit.sv */
// Serial word frame receiver: top level joining registers, frame logic and output buffer.
// Depends on swfr_pkg, swfr_cfg, swfr_frame and swfr_out_buf.
//
// Usage
//   Input channel (in_valid/in_ready): one item is either a received byte
//   (cmd = 0, byte_value) or one elapsed timer tick (cmd = 1).
//   Output channel (out_valid/out_ready): one item per completed word of a
//   frame, with its index, a frame_end flag and the verdict in status.
//   Headers 0x99, 0x13 or 0x14 open a frame; word 1 is the length L and
//   word L carries the verdict against board id and 16-bit word sum.
//   Configuration: APB-style port, board_id at byte 0, timeout_ticks at 4.
// Rate
//   One item is taken every cycle while in_ready is high; the frame state
//   updates in one pass of logic between the accepted item and the result
//   register, which holds the result of the item that completes the word.
// Stall
//   A two-entry output stage (register plus skid) keeps in_ready high while
//   one result waits; in_ready drops only when both entries hold results.
// Reset
//   arst_n clears all state: hunting for a header, timer stopped, output
//   empty, board_id 0 and timeout_ticks 1.
`default_nettype none

module serial_word_frame_receiver_unit #(
	parameter int MAX_WORDS = 128
) (
	input  wire          clk,
	input  wire          arst_n,
	// input items
	input  wire          in_valid,
	output logic         in_ready,
	input  wire          cmd,
	input  wire  [7:0]   byte_value,
	// result items
	output logic         out_valid,
	input  wire          out_ready,
	output logic [15:0]  word_value,
	output logic [6:0]   word_index,
	output logic         frame_end,
	output logic [2:0]   status,
	// configuration
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	swfr_pkg::cfg_t       cfg;
	swfr_pkg::out_item_t  res, out_item;
	logic                 res_valid, take, can_push;

	// no wait states on the register port
	assign pready = 1'b1;

	swfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// advance the frame state on every accepted item
	assign in_ready = can_push;
	assign take     = in_valid & can_push;

	swfr_frame #(
		.MAX_WORDS (MAX_WORDS)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.cmd        (cmd),
		.byte_value (byte_value),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	// hold results here while the receiver stalls
	swfr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take & res_valid),
		.push_item (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign word_value = out_item.word_value;
	assign word_index = out_item.word_index;
	assign frame_end  = out_item.frame_end;
	assign status     = 3'(out_item.status);

endmodule

`default_nettype wire

/* rtl/core/swfr_checker.sv */
// Port-level checks on the serial word frame receiver, bound to the top level.
// Depends on swfr_pkg and serial_word_frame_receiver_unit.
`default_nettype none

module swfr_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         out_valid,
	input wire         out_ready,
	input wire  [6:0]  word_index,
	input wire         frame_end,
	input wire  [2:0]  status
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn under stall");

	// only the closing word carries a verdict
	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == (status != 3'(swfr_pkg::STATUS_IN_FRAME))))
		else $error("frame_end and status disagree");

	// a length rejection is reported on the length word
	a_reject_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 3'(swfr_pkg::STATUS_LEN_BAD) |-> word_index == 7'd1)
		else $error("length rejection away from word one");

	// no undefined verdict code
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(swfr_pkg::STATUS_LEN_BAD))
		else $error("status code out of range");

endmodule

bind serial_word_frame_receiver_unit swfr_checker u_swfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.word_index (word_index),
	.frame_end  (frame_end),
	.status     (status)
);

`default_nettype wire
